// ===== hw/rtl/packed_pixel_unpacker_assert.svh =====
// Assertion macros for the packed pixel unpacker.
// Used by the top level; expects clk and rst_n in scope.
`ifndef PACKED_PIXEL_UNPACKER_ASSERT_SVH
`define PACKED_PIXEL_UNPACKER_ASSERT_SVH

// Checks that an implication holds on every clock edge outside reset.
`define PPU_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Checks that a condition holds on every clock edge outside reset.
`define PPU_ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

`endif

// ===== hw/rtl/ppu_pkg.sv =====
// Shared types, depth codes and helpers for the packed pixel unpacker.
// No dependencies.
package ppu_pkg;

    localparam int PIXEL_W = 24;
    localparam int BYTE_W  = 8;
    localparam int COUNT_W = 5;
    localparam int ACC_W   = PIXEL_W + BYTE_W;
    localparam int MODE_W  = 2;

    localparam logic [COUNT_W-1:0] ACC_MAX = COUNT_W'(PIXEL_W);

    localparam logic [MODE_W-1:0] MODE_10 = 2'd0;
    localparam logic [MODE_W-1:0] MODE_12 = 2'd1;
    localparam logic [MODE_W-1:0] MODE_14 = 2'd2;
    localparam logic [MODE_W-1:0] MODE_24 = 2'd3;

    typedef struct packed {
        logic                   fire;
        logic [PIXEL_W-1:0]     pixel;
        logic [PIXEL_W-1:0]     held;
        logic [COUNT_W-1:0]     count;
    } ppu_result_t;

    function automatic logic [COUNT_W-1:0] depth_bits(input logic [MODE_W-1:0] mode);
        logic [COUNT_W-1:0] d;
        case (mode)
            MODE_10: d = 5'd10;
            MODE_12: d = 5'd12;
            MODE_14: d = 5'd14;
            MODE_24: d = 5'd24;
            default: d = 5'd24;
        endcase
        return d;
    endfunction

    // Mask with the low n bits set; n never exceeds the accumulator width.
    function automatic logic [ACC_W-1:0] low_mask(input logic [COUNT_W:0] n);
        logic [ACC_W:0] m;
        m = ({{ACC_W{1'b0}}, 1'b1} << n) - {{ACC_W{1'b0}}, 1'b1};
        return m[ACC_W-1:0];
    endfunction

endpackage

// ===== hw/rtl/ppu_extract.sv =====
// Combinational bit extraction for one byte of the packed stream.
// Depends on ppu_pkg.
module ppu_extract
    import ppu_pkg::*;
(
    input  logic [PIXEL_W-1:0] held_bits,
    input  logic [COUNT_W-1:0] held_count,
    input  logic [BYTE_W-1:0]  byte_value,
    input  logic               frame_start,
    input  logic [MODE_W-1:0]  depth_mode,
    output ppu_result_t        result
);

    logic [PIXEL_W-1:0] held_in;
    logic [COUNT_W-1:0] count_in;
    logic [COUNT_W:0]   count_sum;
    logic [COUNT_W-1:0] cnt;
    logic [COUNT_W-1:0] depth;
    logic [COUNT_W-1:0] shift_amt;
    logic [ACC_W-1:0]   acc;
    logic [ACC_W-1:0]   shifted;
    logic [ACC_W-1:0]   depth_mask;
    logic [ACC_W-1:0]   keep_mask;

    always_comb
    begin
        held_in  = frame_start ? '0 : held_bits;
        count_in = frame_start ? '0 : held_count;
        depth    = depth_bits(depth_mode);

        // The accumulator keeps at most 24 bits; older bits fall off the top.
        count_sum = {1'b0, count_in} + (COUNT_W+1)'(BYTE_W);
        cnt = (count_sum > {1'b0, ACC_MAX}) ? ACC_MAX : count_sum[COUNT_W-1:0];
        acc = {held_in, byte_value} & low_mask({1'b0, cnt});

        shift_amt  = cnt - depth;
        shifted    = acc >> shift_amt;
        depth_mask = low_mask({1'b0, depth});
        keep_mask  = low_mask({1'b0, shift_amt});

        result.fire = (cnt >= depth);
        result.pixel = shifted[PIXEL_W-1:0] & depth_mask[PIXEL_W-1:0];
        if (result.fire)
        begin
            result.count = shift_amt;
            result.held  = acc[PIXEL_W-1:0] & keep_mask[PIXEL_W-1:0];
        end
        else
        begin
            result.count = cnt;
            result.held  = acc[PIXEL_W-1:0];
        end
    end

endmodule

// ===== hw/rtl/packed_pixel_unpacker.sv =====
// Packed pixel unpacker: 10/12/14/24-bit MSB-first pixels from a byte stream.
// A pixel is registered and appears on the output in the cycle after the byte that completes it.
// Throughput: one byte per cycle unless stalled; the held-bit register updates in the accept cycle.
// Input stalls only while an output item is held under stall.
// Reset clears the held bits, the bit count, the depth mode and the output valid.
// Depends on ppu_pkg, ppu_extract and packed_pixel_unpacker_assert.svh.
`include "packed_pixel_unpacker_assert.svh"

module packed_pixel_unpacker
    import ppu_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_wr_en,
    input  logic [MODE_W-1:0]  cfg_wr_data,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [BYTE_W-1:0]  byte_value,
    input  logic               frame_start,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [PIXEL_W-1:0] pixel_value
);

    logic [MODE_W-1:0]  depth_mode_reg;
    logic [PIXEL_W-1:0] held_bits_reg;
    logic [COUNT_W-1:0] held_count_reg;
    logic               out_valid_reg;
    logic               out_valid_next;
    logic [PIXEL_W-1:0] pixel_reg;
    logic               in_accept;
    logic [ACC_W-1:0]   held_mask;
    ppu_result_t        result;

    ppu_extract u_extract (
        .held_bits   (held_bits_reg),
        .held_count  (held_count_reg),
        .byte_value  (byte_value),
        .frame_start (frame_start),
        .depth_mode  (depth_mode_reg),
        .result      (result)
    );

    assign in_stall  = out_valid_reg && out_stall;
    assign in_accept = in_valid && !in_stall;

    always_comb
    begin
        if (in_accept)
            out_valid_next = result.fire;
        else if (!out_stall)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            depth_mode_reg <= MODE_10;
            held_bits_reg  <= '0;
            held_count_reg <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
                depth_mode_reg <= cfg_wr_data;
            if (in_accept)
            begin
                held_bits_reg  <= result.held;
                held_count_reg <= result.count;
            end
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept && result.fire)
            pixel_reg <= result.pixel;
    end

    assign out_valid   = out_valid_reg;
    assign pixel_value = pixel_reg;

    assign held_mask = low_mask({1'b0, held_count_reg});

    // After any step fewer than a full 24-bit accumulator of bits remain.
    `PPU_ASSERT_ALWAYS(a_count_range, held_count_reg < ACC_MAX, "held count out of range")
    // Bits above the held count must always be zero.
    `PPU_ASSERT_ALWAYS(a_held_clean,
        (held_bits_reg & ~held_mask[PIXEL_W-1:0]) == '0,
        "stray held bits above count")
    // A new output item only appears after an accepted input item.
    `PPU_ASSERT_IMP(a_out_source, $rose(out_valid_reg), $past(in_accept),
        "output item without input item")

endmodule
